// ----- rtl/lfm_pkg.sv -----
// ----------------------------------------------------------------------------
// lfm_pkg
// Shared types and codes for the link failover monitor: transaction payloads,
// configuration view, mode, event and register index codes.
// ----------------------------------------------------------------------------
package lfm_pkg;

   localparam int unsigned CsrIndexWidth = 3;

   localparam logic [2:0] MODE_DISCONNECTED = 3'd0;
   localparam logic [2:0] MODE_CONNECTING   = 3'd1;
   localparam logic [2:0] MODE_CONNECTED    = 3'd2;
   localparam logic [2:0] MODE_DEGRADED     = 3'd3;
   localparam logic [2:0] MODE_RECOVERING   = 3'd4;

   localparam logic [1:0] FUNC_POLL      = 2'd0;
   localparam logic [1:0] FUNC_NOTE      = 2'd1;
   localparam logic [1:0] FUNC_RECONNECT = 2'd2;

   localparam logic [1:0] LINK_NONE = 2'd0;

   localparam logic [CsrIndexWidth-1:0] CSR_PRIMARY_LINK   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_FALLBACK_LINK  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_FAILOVER_DELAY = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_RECOVERY_HOLD  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_GATEWAY_MODE   = 3'd4;

   localparam logic [1:0]  RESET_PRIMARY  = 2'd1;
   localparam logic [1:0]  RESET_FALLBACK = 2'd3;
   localparam logic [31:0] DEFAULT_DELAY  = 32'd5000;
   localparam logic [31:0] DEFAULT_HOLD   = 32'd15000;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] time_ms;
      logic        link_ready;
      logic        received;
      logic        sent_ok;
      logic [31:0] round_trip;
   } req_type;

   typedef struct packed {
      logic [2:0]  link_state;
      logic [1:0]  active_link;
      logic        switch_strobe;
      logic [31:0] failovers;
      logic [31:0] rx_count;
      logic [31:0] tx_count;
      logic [31:0] drop_count;
      logic [31:0] last_round_trip;
      logic [31:0] peak_round_trip;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  primary_link;
      logic [1:0]  fallback_link;
      logic [31:0] delay;
      logic [31:0] half_delay;
      logic [31:0] hold;
      logic        gateway_mode;
   } cfg_type;

endpackage

// ----- rtl/lfm_csr.sv -----
// ----------------------------------------------------------------------------
// lfm_csr
// Configuration registers; substitutes the default delays for zero values.
// ----------------------------------------------------------------------------
module lfm_csr import lfm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]              csr_wdata,
   output cfg_type                  cfg
);

   logic [1:0]  primary_ff;
   logic [1:0]  fallback_ff;
   logic [31:0] delay_ff;
   logic [31:0] hold_ff;
   logic        gateway_ff;
   logic [31:0] eff_delay;

   always_ff @(posedge clock) begin
      if (reset) begin
         primary_ff  <= RESET_PRIMARY;
         fallback_ff <= RESET_FALLBACK;
         delay_ff    <= DEFAULT_DELAY;
         hold_ff     <= DEFAULT_HOLD;
         gateway_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PRIMARY_LINK:   primary_ff  <= csr_wdata[1:0];
            CSR_FALLBACK_LINK:  fallback_ff <= csr_wdata[1:0];
            CSR_FAILOVER_DELAY: delay_ff    <= csr_wdata;
            CSR_RECOVERY_HOLD:  hold_ff     <= csr_wdata;
            CSR_GATEWAY_MODE:   gateway_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign eff_delay = (delay_ff == 32'd0) ? DEFAULT_DELAY : delay_ff;

   always_comb begin
      cfg.primary_link  = primary_ff;
      cfg.fallback_link = fallback_ff;
      cfg.delay         = eff_delay;
      cfg.half_delay    = {1'b0, eff_delay[31:1]};
      cfg.hold          = (hold_ff == 32'd0) ? DEFAULT_HOLD : hold_ff;
      cfg.gateway_mode  = gateway_ff;
   end

endmodule

// ----- rtl/lfm_engine.sv -----
// ----------------------------------------------------------------------------
// lfm_engine
// Monitor state and its single-pass update for one event transaction.
// ----------------------------------------------------------------------------
module lfm_engine import lfm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type result
);

   logic        started_ff,        started_in;
   logic [2:0]  mode_ff,           mode_in;
   logic [31:0] last_good_ff,      last_good_in;
   logic [31:0] degraded_since_ff, degraded_since_in;
   logic [31:0] retry_since_ff,    retry_since_in;
   logic [1:0]  link_ff,           link_in;
   logic [31:0] failover_total_ff, failover_total_in;
   logic [31:0] rx_total_ff,       rx_total_in;
   logic [31:0] tx_total_ff,       tx_total_in;
   logic [31:0] drop_total_ff,     drop_total_in;
   logic [31:0] recent_rtt_ff,     recent_rtt_in;
   logic [31:0] peak_rtt_ff,       peak_rtt_in;
   logic        strobe;
   logic [31:0] silence;
   logic [31:0] in_degraded;
   logic [31:0] in_retry;

   assign silence     = req.time_ms - last_good_ff;
   assign in_degraded = req.time_ms - degraded_since_ff;
   assign in_retry    = req.time_ms - retry_since_ff;

   always_comb begin
      started_in        = started_ff;
      mode_in           = mode_ff;
      last_good_in      = last_good_ff;
      degraded_since_in = degraded_since_ff;
      retry_since_in    = retry_since_ff;
      link_in           = link_ff;
      failover_total_in = failover_total_ff;
      rx_total_in       = rx_total_ff;
      tx_total_in       = tx_total_ff;
      drop_total_in     = drop_total_ff;
      recent_rtt_in     = recent_rtt_ff;
      peak_rtt_in       = peak_rtt_ff;
      strobe            = 1'b0;
      case (req.func)
         FUNC_POLL: begin
            if (!started_ff) begin
               started_in        = 1'b1;
               failover_total_in = 32'd0;
               rx_total_in       = 32'd0;
               tx_total_in       = 32'd0;
               drop_total_in     = 32'd0;
               recent_rtt_in     = 32'd0;
               peak_rtt_in       = 32'd0;
               link_in           = cfg.primary_link;
               mode_in           = MODE_CONNECTING;
               last_good_in      = req.time_ms;
               if (req.link_ready) begin
                  mode_in = MODE_CONNECTED;
               end
            end else begin
               case (mode_ff)
                  MODE_DISCONNECTED: begin
                     if (req.link_ready) begin
                        mode_in = MODE_CONNECTING;
                     end
                  end
                  MODE_CONNECTING: begin
                     if (req.link_ready) begin
                        mode_in      = MODE_CONNECTED;
                        last_good_in = req.time_ms;
                     end
                  end
                  MODE_CONNECTED: begin
                     if (!cfg.gateway_mode && silence > cfg.delay &&
                         cfg.fallback_link != LINK_NONE) begin
                        mode_in           = MODE_DEGRADED;
                        degraded_since_in = req.time_ms;
                        failover_total_in = failover_total_ff + 32'd1;
                        link_in           = cfg.fallback_link;
                        strobe            = 1'b1;
                     end
                  end
                  MODE_DEGRADED: begin
                     if (in_degraded >= cfg.hold) begin
                        mode_in        = MODE_RECOVERING;
                        retry_since_in = req.time_ms;
                        link_in        = cfg.primary_link;
                        strobe         = 1'b1;
                     end
                  end
                  MODE_RECOVERING: begin
                     if (req.link_ready && silence < cfg.delay) begin
                        mode_in = MODE_CONNECTED;
                     end else if (in_retry > cfg.half_delay) begin
                        mode_in           = MODE_DEGRADED;
                        degraded_since_in = req.time_ms;
                        link_in           = cfg.fallback_link;
                        strobe            = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         FUNC_NOTE: begin
            if (req.received) begin
               rx_total_in  = rx_total_ff + 32'd1;
               last_good_in = req.time_ms;
            end else begin
               tx_total_in = tx_total_ff + 32'd1;
               if (!req.sent_ok) begin
                  drop_total_in = drop_total_ff + 32'd1;
               end
            end
            if (req.round_trip != 32'd0) begin
               recent_rtt_in = req.round_trip;
               if (req.round_trip > peak_rtt_ff) begin
                  peak_rtt_in = req.round_trip;
               end
            end
         end
         FUNC_RECONNECT: begin
            mode_in      = MODE_CONNECTING;
            last_good_in = req.time_ms;
            link_in      = cfg.primary_link;
            strobe       = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff        <= 1'b0;
         mode_ff           <= MODE_DISCONNECTED;
         last_good_ff      <= 32'd0;
         degraded_since_ff <= 32'd0;
         retry_since_ff    <= 32'd0;
         link_ff           <= LINK_NONE;
         failover_total_ff <= 32'd0;
         rx_total_ff       <= 32'd0;
         tx_total_ff       <= 32'd0;
         drop_total_ff     <= 32'd0;
         recent_rtt_ff     <= 32'd0;
         peak_rtt_ff       <= 32'd0;
      end else if (step) begin
         started_ff        <= started_in;
         mode_ff           <= mode_in;
         last_good_ff      <= last_good_in;
         degraded_since_ff <= degraded_since_in;
         retry_since_ff    <= retry_since_in;
         link_ff           <= link_in;
         failover_total_ff <= failover_total_in;
         rx_total_ff       <= rx_total_in;
         tx_total_ff       <= tx_total_in;
         drop_total_ff     <= drop_total_in;
         recent_rtt_ff     <= recent_rtt_in;
         peak_rtt_ff       <= peak_rtt_in;
      end
   end

   always_comb begin
      result.link_state      = mode_in;
      result.active_link     = link_in;
      result.switch_strobe   = strobe;
      result.failovers       = failover_total_in;
      result.rx_count        = rx_total_in;
      result.tx_count        = tx_total_in;
      result.drop_count      = drop_total_in;
      result.last_round_trip = recent_rtt_in;
      result.peak_round_trip = peak_rtt_in;
   end

`ifndef SYNTHESIS
   a_reconnect_mode: assert property (@(posedge clock) disable iff (reset)
      step && req.func == FUNC_RECONNECT |=> mode_ff == MODE_CONNECTING)
      else $error("forced reconnect did not enter connecting");

   a_rx_count: assert property (@(posedge clock) disable iff (reset)
      step && started_ff && req.func == FUNC_NOTE && req.received
      |=> rx_total_ff == $past(rx_total_ff) + 32'd1)
      else $error("received packet not counted");

   a_started_holds: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("started flag cleared without reset");

   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      peak_rtt_ff >= recent_rtt_ff)
      else $error("peak round trip below latest round trip");
`endif

endmodule

// ----- rtl/link_failover_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// link_failover_monitor_unit
// Link failover monitor: event transactions in, one status transaction out
// per event.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  req_payload (req_type)
//   rsp_     out        rsp_valid / rsp_ready  rsp_payload (rsp_type)
//   csr_     in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One transaction a cycle while rsp_ready is high, set by the single update
// pass of the monitor state; rsp_valid comes from the output register.
// Reset clears the monitor state and loads the default configuration.
// With rsp_ready low the result holds, one more event waits in the input
// register, and then req_ready drops. csr_ready is always high.
// ----------------------------------------------------------------------------
module link_failover_monitor_unit import lfm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]              csr_wdata
);

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    step;
   cfg_type cfg;
   rsp_type result;

   assign csr_ready = 1'b1;
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   lfm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lfm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .req    (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (step) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule
